[sv/fmq_pkg.sv]
`default_nettype none

package fmq_pkg;

   localparam int DEPTH     = 16;
   localparam int WORD_BITS = 32;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   localparam logic signed [31:0] MATCH_RESET = 32'sd10;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [CNT_BITS-1:0]  count_type;

   typedef enum logic [1:0] {
      MODE_PUSH   = 2'd0,
      MODE_POP    = 2'd1,
      MODE_REMOVE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_NOMATCH = 2'd3
   } status_type;

   typedef struct packed {
      logic     push;
      logic     pop;
      logic     remove;
      word_type push_word;
      word_type key;
   } cell_ctrl_type;

   function automatic word_type to_word(input logic [31:0] v);
      logic [63:0] wide;
      wide = {{32{v[31]}}, v};
      return wide[WORD_BITS-1:0];
   endfunction

   function automatic logic [31:0] to_out(input word_type w);
      logic [63:0] wide;
      wide = 64'(w);
      return wide[31:0];
   endfunction

   localparam logic [31:0] EMPTY_POP = to_out({WORD_BITS{1'b1}});
   localparam logic [4:0]  FULL_OCC  = 5'(DEPTH);

endpackage

`default_nettype wire

[sv/fmq_cell.sv]
`default_nettype none

module fmq_cell (
   input  wire logic                  clock,
   input  wire fmq_pkg::cell_ctrl_type ctrl,
   input  wire logic                  tail_sel,
   input  wire logic                  live,
   input  wire logic                  found_in,
   input  wire fmq_pkg::word_type     next_data,
   output      logic                  found_out,
   output      fmq_pkg::word_type     data
);
   import fmq_pkg::*;

   word_type data_ff;
   word_type data_in;
   logic     shift;

   assign found_out = found_in | (live && (data_ff == ctrl.key));
   assign shift     = ctrl.pop | (ctrl.remove & found_out);
   assign data      = data_ff;

   always_comb begin
      priority if (ctrl.push && tail_sel) begin
         data_in = ctrl.push_word;
      end else if (shift) begin
         data_in = next_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

[sv/fifo_queue_with_match_delete.sv]
// An accepted request's response is registered and shown in the cycle after acceptance.
// Throughput: one item per cycle; every cell compares and shifts in parallel,
// with the match flag rippling head to tail along the row of cells.
// A response that waits holds off the next request until it is taken.
// Reset (synchronous, active high) empties the queue, drops any pending
// response and sets the match value to 10; cell contents are not cleared.
`default_nettype none

module fifo_queue_with_match_delete (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic signed [31:0] req_push_value,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic signed [31:0] rsp_pop_value,
   output      logic [1:0]  rsp_status,
   output      logic [4:0]  rsp_occupancy,
   input  wire logic        csr_write_enable,
   input  wire logic signed [31:0] csr_write_data
);
   import fmq_pkg::*;

   logic signed [31:0] match_ff;
   count_type          count_ff;
   count_type          count_in;
   logic               rsp_valid_ff;
   logic [31:0]        pop_ff;
   logic [31:0]        pop_in;
   status_type         status_ff;
   status_type         status_in;
   logic               accept;
   logic               full;
   logic               empty;
   cell_ctrl_type      ctrl;
   word_type           data [DEPTH];
   logic [DEPTH:0]     found;

   assign req_ready     = !rsp_valid_ff || rsp_ready;
   assign accept        = req_valid && req_ready;
   assign full          = (count_ff == CNT_BITS'(DEPTH));
   assign empty         = (count_ff == '0);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pop_value = pop_ff;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = count_ff[4:0];

   always_comb begin
      ctrl.push      = accept && (req_mode == MODE_PUSH);
      ctrl.pop       = accept && (req_mode == MODE_POP) && !empty;
      ctrl.remove    = accept && (req_mode == MODE_REMOVE);
      ctrl.push_word = to_word(req_push_value);
      ctrl.key       = to_word(match_ff);
   end

   assign found[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      word_type nxt;
      if (i == DEPTH - 1) begin : g_last
         assign nxt = data[i];
      end else begin : g_mid
         assign nxt = data[i+1];
      end
      fmq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .tail_sel  (count_ff == CNT_BITS'(i)),
         .live      (CNT_BITS'(i) < count_ff),
         .found_in  (found[i]),
         .next_data (nxt),
         .found_out (found[i+1]),
         .data      (data[i])
      );
   end

   always_comb begin
      count_in  = count_ff;
      pop_in    = '0;
      status_in = STATUS_DONE;
      unique case (req_mode)
         MODE_PUSH: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + CNT_BITS'(1);
            end
         end
         MODE_POP: begin
            if (empty) begin
               pop_in    = EMPTY_POP;
               status_in = STATUS_EMPTY;
            end else begin
               pop_in   = to_out(data[0]);
               count_in = count_ff - CNT_BITS'(1);
            end
         end
         MODE_REMOVE: begin
            if (found[DEPTH]) begin
               count_in = count_ff - CNT_BITS'(1);
            end else begin
               status_in = STATUS_NOMATCH;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff     <= MATCH_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            match_ff <= csr_write_data;
         end
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pop_ff    <= pop_in;
         status_ff <= status_in;
      end
   end

endmodule

`default_nettype wire

[sv/fmq_checker.sv]
`default_nettype none

module fmq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_pop_value,
   input wire logic [1:0]  rsp_status,
   input wire logic [4:0]  rsp_occupancy
);
   import fmq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pop_value)
         && $stable(rsp_status) && $stable(rsp_occupancy))
      else $error("response changed while stalled");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EMPTY) |->
         (rsp_occupancy == 5'd0) && (rsp_pop_value == EMPTY_POP))
      else $error("empty pop with wrong value or occupancy");

   a_full_push: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |-> rsp_occupancy == FULL_OCC)
      else $error("push dropped while not full");

   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == STATUS_FULL) || (rsp_status == STATUS_NOMATCH))
         |-> rsp_pop_value == 32'd0)
      else $error("nonzero value on failed push or remove");

endmodule

bind fifo_queue_with_match_delete fmq_checker u_fmq_checker (.*);

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   import fmq_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 300000;

   typedef struct {
      logic [31:0] pop_value;
      status_type  status;
      logic [4:0]  occupancy;
   } rsp_fields_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = MODE_PUSH;
   logic signed [31:0] req_push_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic signed [31:0] rsp_pop_value;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_occupancy;
   logic        csr_write_enable = 1'b0;
   logic signed [31:0] csr_write_data = '0;

   word_type    model_q[$];
   logic [31:0] model_match = MATCH_RESET;
   rsp_fields_type pending_rsp[$];

   int fail_count      = 0;
   int cycle_count     = 0;
   int hold_off_cycles = 0;
   int stall_left      = 0;
   bit no_idle         = 1'b0;

   fifo_queue_with_match_delete dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pop_value    (rsp_pop_value),
      .rsp_status       (rsp_status),
      .rsp_occupancy    (rsp_occupancy),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic rsp_fields_type apply_queue_op(input logic [1:0] mode,
                                                     input logic [31:0] value);
      rsp_fields_type r;
      word_type       key;
      int             hit;
      r.pop_value = '0;
      r.status    = STATUS_DONE;
      hit         = -1;
      key         = word_type'(signed'(model_match));
      case (mode)
         MODE_PUSH: begin
            if (model_q.size() >= DEPTH) r.status = STATUS_FULL;
            else model_q.push_back(word_type'(signed'(value)));
         end
         MODE_POP: begin
            if (model_q.size() == 0) begin
               r.pop_value = 32'({WORD_BITS{1'b1}});
               r.status    = STATUS_EMPTY;
            end else begin
               r.pop_value = 32'(model_q.pop_front());
            end
         end
         MODE_REMOVE: begin
            for (int i = 0; i < model_q.size(); i++) begin
               if (hit < 0 && model_q[i] == key) hit = i;
            end
            if (hit < 0) r.status = STATUS_NOMATCH;
            else model_q.delete(hit);
         end
         default: ;
      endcase
      r.occupancy = 5'(model_q.size());
      return r;
   endfunction

   function automatic int idle_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   // receiver side: random stalls plus an optional long hold-off
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_off_cycles--;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0) stall_left = idle_gap();
         end
      end
   end

   always @(posedge clock) begin
      rsp_fields_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: response with nothing expected: pop_value %h status %0d occ %0d",
                     $time, rsp_pop_value, rsp_status, rsp_occupancy);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_pop_value !== want.pop_value) begin
               $display("%0t: pop_value expected %h actual %h",
                        $time, want.pop_value, rsp_pop_value);
               fail_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_status);
               fail_count++;
            end
            if (rsp_occupancy !== want.occupancy) begin
               $display("%0t: occupancy expected %0d actual %0d",
                        $time, want.occupancy, rsp_occupancy);
               fail_count++;
            end
         end
      end
   end

   // entered and left at a falling edge; valid stays high on return
   task automatic send_item(input logic [1:0] mode, input logic [31:0] value);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode       <= mode;
      req_push_value <= value;
      req_valid      <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(apply_queue_op(mode, value));
      @(negedge clock);
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_match_value(input logic [31:0] value);
      wait_for_responses();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      model_match = value;
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 4))
         0, 1:    return model_match;
         2:       return $urandom();
         3:       return $urandom_range(0, 15);
         default: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff};
      endcase
   endfunction

   function automatic logic [1:0] pick_mode(input int push_w, input int pop_w,
                                            input int remove_w);
      int r;
      r = $urandom_range(0, 99);
      if (r < push_w) return MODE_PUSH;
      if (r < push_w + pop_w) return MODE_POP;
      if (r < push_w + pop_w + remove_w) return MODE_REMOVE;
      return MODE_UNUSED;
   endfunction

   task automatic test_empty_queue();
      send_item(MODE_POP, 32'h1234_5678);
      send_item(MODE_REMOVE, 32'h0);
      send_item(MODE_UNUSED, 32'hffff_ffff);
   endtask

   task automatic test_fill_and_overflow();
      send_item(MODE_PUSH, 32'd10);
      send_item(MODE_PUSH, 32'h7fff_ffff);
      send_item(MODE_PUSH, 32'h8000_0000);
      send_item(MODE_PUSH, 32'hffff_ffff);
      send_item(MODE_PUSH, 32'h0);
      send_item(MODE_PUSH, 32'd10);
      repeat (DEPTH - 6) send_item(MODE_PUSH, $urandom());
      send_item(MODE_PUSH, 32'd10);
      send_item(MODE_UNUSED, 32'h0);
   endtask

   task automatic test_match_delete();
      send_item(MODE_REMOVE, 32'h0);
      send_item(MODE_REMOVE, 32'h0);
      send_item(MODE_REMOVE, 32'h0);
      send_item(MODE_POP, 32'h0);
      send_item(MODE_POP, 32'h0);
   endtask

   task automatic run_random_phase(input int count, input int push_w,
                                   input int pop_w, input int remove_w);
      repeat (count) begin
         send_item(pick_mode(push_w, pop_w, remove_w), pick_value());
         if ($urandom_range(0, 99) == 0) wait_for_responses();
      end
   endtask

   task automatic test_random_settings();
      run_random_phase(120, 40, 30, 25);
      write_match_value(32'h8000_0000);
      run_random_phase(120, 60, 15, 20);
      write_match_value(32'h7fff_ffff);
      run_random_phase(120, 25, 45, 25);
      write_match_value(32'hffff_ffff);
      no_idle = 1'b1;
      run_random_phase(100, 40, 30, 25);
      no_idle = 1'b0;
      write_match_value(32'h0);
      run_random_phase(120, 45, 15, 35);
      write_match_value($urandom());
      run_random_phase(120, 40, 30, 25);
   endtask

   task automatic test_output_backpressure();
      write_match_value(MATCH_RESET);
      hold_off_cycles = 120;
      run_random_phase(40, 50, 25, 20);
      wait_for_responses();
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_empty_queue();
      test_fill_and_overflow();
      test_match_delete();
      test_random_settings();
      test_output_backpressure();
      wait_for_responses();
      repeat (5) @(negedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
